>>> hw/rtl/frp_pkg.sv
// Shared types, sizes and codes of the frontlight power resolver.
// Used by frp_tables and frontlight_power_resolver_core; depends on nothing.
package frp_pkg;

    localparam int LEVEL_STEPS = 32;
    localparam int DRIVE_STEPS = 64;
    localparam int LW          = $clog2(LEVEL_STEPS);
    localparam int DW          = $clog2(DRIVE_STEPS);
    localparam int AW          = (DW > LW) ? DW : LW;
    localparam int CODE_W      = 16;
    localparam int PWR_W       = 24;
    localparam int REQ_W       = PWR_W + 1;
    localparam int MULT_W      = 16;
    localparam int PCT_W       = 8;
    localparam int CAP_FRAC    = 12;
    localparam int CAPP_W      = PWR_W + MULT_W;
    localparam int DEN_W       = LW + 1 + 7;
    localparam int NUM_W       = REQ_W + LW + PCT_W;
    localparam int PROD_W      = PWR_W + DEN_W;
    localparam int INT_W       = LW + 2;
    localparam int X_W         = 16;

    // Divide by one hundred through a reciprocal, exact for the operand range used here.
    localparam int DIV100_MUL  = 5243;
    localparam int DIV100_SH   = 19;
    localparam int PCT_FULL    = 100;
    localparam int PCT_HALF    = 50;
    localparam int WARM_LIM    = 20;

    // Request function codes.
    localparam logic [2:0] FN_WR_LVL   = 3'd0;
    localparam logic [2:0] FN_WR_COLD  = 3'd1;
    localparam logic [2:0] FN_WR_WARM  = 3'd2;
    localparam logic [2:0] FN_WR_DCODE = 3'd3;
    localparam logic [2:0] FN_WR_DPWR  = 3'd4;
    localparam logic [2:0] FN_CODE     = 3'd5;
    localparam logic [2:0] FN_PCT      = 3'd6;
    localparam logic [2:0] FN_DIRECT   = 3'd7;

    typedef struct packed {
        logic              en;
        logic [2:0]        sel;
        logic [5:0]        idx;
        logic [PWR_W-1:0]  val;
    } t_tbl_wr;

    typedef struct packed {
        logic [CODE_W-1:0] lc;
        logic [PWR_W-1:0]  cp;
        logic [PWR_W-1:0]  wp;
    } t_lvl_rd;

    typedef struct packed {
        logic [CODE_W-1:0] dc;
        logic [PWR_W-1:0]  dp;
    } t_drv_rd;

endpackage

>>> hw/rtl/frontlight_power_resolver_core.sv
// Top level of the frontlight power resolver: request sequencer, arithmetic and result register.
// Depends on frp_pkg and frp_tables.
//
//  Channel   Direction  Handshake                         Word
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready   tuser func, tdata request fields
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready   tuser valid_res, tdata result fields
//  cfg       in         i_cfg_valid/o_cfg_ready           index and register data
//
// Table writes and percents above 100 go straight to the result. Direct mode runs the percent
// conversion and the level pass; code mode runs the level pass, the power arithmetic and both
// drive passes, and percent mode adds the conversion before them. Passes use one read port per
// table group; a bad level table or a zero register ends the request after the level pass.
// Reset is synchronous; tables read as zero until written, without a clearing pass.
// A new word is taken while the previous result waits on a stalled m_axis.
module frontlight_power_resolver_core
    import frp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata: table_index[5:0], table_value[29:6], cold_request_code[45:30],
    //        warm_request_code[61:46], brightness_pct[68:62], warmth_pct[75:69]
    input  logic [79:0]  i_s_axis_tdata,
    // tuser: func[2:0]
    input  logic [2:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tdata: cold_level_step[4:0], warm_level_step[9:5], cold_drv_idx[15:10],
    //        warm_drv_idx[21:16], cold_out_code[37:22], warm_out_code[53:38],
    //        requested_power[78:54], applied_power[103:79], cold_drv_power[127:104],
    //        warm_drv_power[151:128], capped[152]
    output logic [159:0] o_m_axis_tdata,
    // tuser: valid_res[0]
    output logic [0:0]   o_m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [0:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    localparam logic [0:0] CFG_CAP_MULT = 1'd0;
    localparam logic [0:0] CFG_WARM_PCT = 1'd1;
    localparam logic [AW-1:0] LVL_LAST = AW'(LEVEL_STEPS - 1);
    localparam logic [AW-1:0] DRV_LAST = AW'(DRIVE_STEPS - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_P0, S_P1, S_P2, S_P3, S_P4, S_LSCAN, S_LCHK,
        S_C0, S_C1, S_C2, S_C3, S_C4, S_C5, S_WSCAN, S_CPREP, S_CSCAN, S_DONE
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [MULT_W-1:0] r_cap_mult;
    logic [PCT_W-1:0]  r_warm_pct;

    // Latched request.
    logic [2:0]        r_func;
    logic [CODE_W-1:0] r_ccode, r_wcode;
    logic [6:0]        r_bp, r_wp;

    // Percent conversion.
    logic [X_W-1:0]    r_x, r_pa, r_pb;
    logic [INT_W-1:0]  r_int;

    // Result fields under construction.
    logic              r_ok, r_drv_ok, r_lvl_ok, r_cap;
    logic [LW-1:0]     r_cs, r_ws;
    logic [DW-1:0]     r_cd, r_wd;
    logic [CODE_W-1:0] r_coc, r_woc;
    logic [REQ_W-1:0]  r_req, r_app, r_ctgt;
    logic [PWR_W-1:0]  r_acp, r_awp, r_cp, r_wpw, r_cptop;
    logic [CAPP_W-1:0] r_capprod;
    logic [NUM_W-1:0]  r_num, r_lim;
    logic [DEN_W-1:0]  r_den;

    // Scan state.
    logic [AW-1:0]     r_addr, r_s1_idx, r_s2_idx;
    logic              r_iss_done, r_s1_vld, r_s2_vld;
    logic [CODE_W-1:0] r_bdc, r_bdw, r_prev_code;
    logic [NUM_W-1:0]  r_bd;
    logic [PROD_W-1:0] r_s2_prod;
    logic [CODE_W-1:0] r_s2_code;
    logic [PWR_W-1:0]  r_s2_pow;

    // Output register.
    logic              r_m_valid;
    logic [159:0]      r_m_tdata;
    logic [0:0]        r_m_tuser;

    t_tbl_wr tbl_wr;
    t_lvl_rd lvl_rd;
    t_drv_rd drv_rd;

    logic              accept, in_range, scanning, drive_scan, last_issue;
    logic [CODE_W-1:0] dist_c, dist_w;
    logic              code_mode, hit_c, hit_w, l_first;
    logic [NUM_W-1:0]  s2_tgt, s2_prod_x, dist_d;
    logic              hit_d, out_free;

    frp_tables u_tables (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (tbl_wr),
        .i_lvl_addr (r_addr[LW-1:0]),
        .i_drv_addr (r_addr[DW-1:0]),
        .o_lvl      (lvl_rd),
        .o_drv      (drv_rd)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tuser  = r_m_tuser;
    assign out_free        = !r_m_valid || i_m_axis_tready;

    // Table write request straight from the accepted word.
    always_comb begin
        if (i_s_axis_tuser <= FN_WR_WARM) begin
            in_range = int'(i_s_axis_tdata[5:0]) < LEVEL_STEPS;
        end else begin
            in_range = int'(i_s_axis_tdata[5:0]) < DRIVE_STEPS;
        end
        tbl_wr.en  = accept && (i_s_axis_tuser <= FN_WR_DPWR) && in_range;
        tbl_wr.sel = i_s_axis_tuser;
        tbl_wr.idx = i_s_axis_tdata[5:0];
        tbl_wr.val = i_s_axis_tdata[29:6];
    end

    // Scan address issue control.
    assign scanning   = (r_state == S_LSCAN) || (r_state == S_WSCAN) || (r_state == S_CSCAN);
    assign drive_scan = (r_state == S_WSCAN) || (r_state == S_CSCAN);
    assign last_issue = (r_addr == (drive_scan ? DRV_LAST : LVL_LAST));

    // Level pass: nearest code for each request, or the fixed step in percent and direct mode.
    always_comb begin
        code_mode = (r_func == FN_CODE);
        l_first   = (r_s1_idx == '0);
        dist_c    = (lvl_rd.lc > r_ccode) ? lvl_rd.lc - r_ccode : r_ccode - lvl_rd.lc;
        dist_w    = (lvl_rd.lc > r_wcode) ? lvl_rd.lc - r_wcode : r_wcode - lvl_rd.lc;
        if (code_mode) begin
            hit_c = l_first || (dist_c < r_bdc);
            hit_w = l_first || (dist_w < r_bdw);
        end else begin
            hit_c = (r_s1_idx[LW-1:0] == r_cs);
            hit_w = (r_s1_idx[LW-1:0] == r_ws);
        end
    end

    // Drive pass: distance of scaled drive power from the target.
    always_comb begin
        s2_tgt    = (r_state == S_WSCAN) ? r_num : NUM_W'(r_ctgt);
        s2_prod_x = NUM_W'(r_s2_prod);
        dist_d    = (s2_prod_x > s2_tgt) ? s2_prod_x - s2_tgt : s2_tgt - s2_prod_x;
        hit_d     = (r_s2_idx == '0) || (dist_d < r_bd);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_mult <= MULT_W'(4096);
            r_warm_pct <= PCT_W'(PCT_FULL);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CAP_MULT: r_cap_mult <= i_cfg_data[MULT_W-1:0];
                CFG_WARM_PCT: r_warm_pct <= i_cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // Request sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_valid  <= 1'b0;
            r_iss_done <= 1'b0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_addr     <= '0;
        end else begin
            // A finished request reloads the output register itself.
            if (r_m_valid && i_m_axis_tready && (r_state != S_DONE)) begin
                r_m_valid <= 1'b0;
            end

            // Scan pipeline: address, registered table data, product.
            if (scanning && !r_iss_done) begin
                r_addr <= r_addr + 1'b1;
                if (last_issue) begin
                    r_iss_done <= 1'b1;
                end
            end
            r_s1_vld  <= scanning && !r_iss_done;
            r_s1_idx  <= r_addr;
            r_s2_vld  <= r_s1_vld && drive_scan;
            r_s2_idx  <= r_s1_idx;
            r_s2_prod <= drv_rd.dp * ((r_state == S_WSCAN) ? r_den : DEN_W'(1));
            r_s2_code <= drv_rd.dc;
            r_s2_pow  <= drv_rd.dp;

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_func     <= i_s_axis_tuser;
                        r_ccode    <= i_s_axis_tdata[45:30];
                        r_wcode    <= i_s_axis_tdata[61:46];
                        r_bp       <= i_s_axis_tdata[68:62];
                        r_wp       <= i_s_axis_tdata[75:69];
                        r_ok       <= 1'b0;
                        r_drv_ok   <= 1'b1;
                        r_lvl_ok   <= 1'b1;
                        r_cap      <= 1'b0;
                        r_cs       <= '0;
                        r_ws       <= '0;
                        r_cd       <= '0;
                        r_wd       <= '0;
                        r_coc      <= '0;
                        r_woc      <= '0;
                        r_req      <= '0;
                        r_app      <= '0;
                        r_acp      <= '0;
                        r_awp      <= '0;
                        r_addr     <= '0;
                        r_iss_done <= 1'b0;
                        if (i_s_axis_tuser <= FN_WR_DPWR) begin
                            r_ok    <= in_range;
                            r_state <= S_DONE;
                        end else if (i_s_axis_tuser == FN_CODE) begin
                            r_state <= S_LSCAN;
                        end else if ((int'(i_s_axis_tdata[68:62]) > PCT_FULL) ||
                                     (int'(i_s_axis_tdata[75:69]) > PCT_FULL)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_P0;
                        end
                    end
                end
                // Percents to steps.
                S_P0: begin
                    r_x     <= X_W'(r_bp) * X_W'(LEVEL_STEPS - 1) + X_W'(PCT_HALF);
                    r_state <= S_P1;
                end
                S_P1: begin
                    r_int   <= INT_W'((32'(r_x) * 32'(DIV100_MUL)) >> DIV100_SH);
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_pa <= X_W'(r_int) * (X_W'(PCT_FULL) - X_W'(r_wp));
                    if (r_func == FN_DIRECT) begin
                        r_pb <= X_W'(r_int) * X_W'(r_wp) + X_W'(PCT_HALF);
                    end else begin
                        r_pb <= X_W'(r_int) * X_W'(r_wp);
                    end
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_ws    <= LW'((32'(r_pb) * 32'(DIV100_MUL)) >> DIV100_SH);
                    r_cs    <= LW'((32'(r_pa) * 32'(DIV100_MUL)) >> DIV100_SH);
                    r_state <= (r_func == FN_DIRECT) ? S_P4 : S_LSCAN;
                end
                S_P4: begin
                    r_cs    <= LW'(r_int) - r_ws;
                    r_state <= S_LSCAN;
                end
                // Level pass with calibration check.
                S_LSCAN: begin
                    if (r_s1_vld) begin
                        r_prev_code <= lvl_rd.lc;
                        if (l_first ? (lvl_rd.lc != '0) : (lvl_rd.lc <= r_prev_code)) begin
                            r_lvl_ok <= 1'b0;
                        end
                        if (hit_c) begin
                            r_bdc <= dist_c;
                            r_cp  <= lvl_rd.cp;
                            r_coc <= lvl_rd.lc;
                            if (code_mode) begin
                                r_cs <= r_s1_idx[LW-1:0];
                            end
                        end
                        if (hit_w) begin
                            r_bdw <= dist_w;
                            r_wpw <= lvl_rd.wp;
                            r_woc <= lvl_rd.lc;
                            if (code_mode) begin
                                r_ws <= r_s1_idx[LW-1:0];
                            end
                        end
                        if (r_s1_idx == LVL_LAST) begin
                            r_cptop <= lvl_rd.cp;
                            r_state <= S_LCHK;
                        end
                    end
                end
                S_LCHK: begin
                    if (!r_lvl_ok) begin
                        r_state <= S_DONE;
                    end else if (r_func == FN_DIRECT) begin
                        r_ok    <= 1'b1;
                        r_state <= S_DONE;
                    end else if ((r_cap_mult == '0) || (r_warm_pct == '0)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_coc   <= '0;
                        r_woc   <= '0;
                        r_state <= S_C0;
                    end
                end
                // Power sum, cap and warm target.
                S_C0: begin
                    r_req     <= REQ_W'(r_cp) + REQ_W'(r_wpw);
                    r_capprod <= r_cptop * r_cap_mult;
                    r_state   <= S_C1;
                end
                S_C1: begin
                    if ({3'b0, r_req, {CAP_FRAC{1'b0}}} > r_capprod) begin
                        r_cap <= 1'b1;
                        r_app <= REQ_W'(r_capprod >> CAP_FRAC);
                    end else begin
                        r_app <= r_req;
                    end
                    r_state <= S_C2;
                end
                S_C2: begin
                    if ((r_cs == '0) && (r_ws == '0)) begin
                        r_den <= DEN_W'(1);
                        r_num <= '0;
                    end else begin
                        r_den <= DEN_W'(r_cs) + DEN_W'(r_ws);
                        r_num <= NUM_W'(r_app) * NUM_W'(r_ws);
                    end
                    r_state <= S_C3;
                end
                S_C3: begin
                    if (int'(r_ws) > WARM_LIM) begin
                        r_num <= r_num * NUM_W'(r_warm_pct);
                        r_den <= r_den * DEN_W'(PCT_FULL);
                    end
                    r_state <= S_C4;
                end
                S_C4: begin
                    r_lim   <= NUM_W'(r_app) * NUM_W'(r_den);
                    r_state <= S_C5;
                end
                S_C5: begin
                    if (r_num > r_lim) begin
                        r_num <= r_lim;
                    end
                    r_addr     <= '0;
                    r_iss_done <= 1'b0;
                    r_state    <= S_WSCAN;
                end
                // Drive passes: warm share first, then cold from the remainder.
                S_WSCAN, S_CSCAN: begin
                    if (r_s1_vld && (r_s1_idx != '0) && (drv_rd.dc <= r_prev_code)) begin
                        r_drv_ok <= 1'b0;
                    end
                    if (r_s1_vld) begin
                        r_prev_code <= drv_rd.dc;
                    end
                    if (r_s2_vld) begin
                        if (hit_d) begin
                            r_bd <= dist_d;
                            if (r_state == S_WSCAN) begin
                                r_wd  <= r_s2_idx[DW-1:0];
                                r_woc <= r_s2_code;
                                r_awp <= r_s2_pow;
                            end else begin
                                r_cd  <= r_s2_idx[DW-1:0];
                                r_coc <= r_s2_code;
                                r_acp <= r_s2_pow;
                            end
                        end
                        if (r_s2_idx == DRV_LAST) begin
                            if (r_state == S_WSCAN) begin
                                r_state <= S_CPREP;
                            end else begin
                                r_ok    <= 1'b1;
                                r_state <= S_DONE;
                            end
                        end
                    end
                end
                S_CPREP: begin
                    r_ctgt     <= (r_app > REQ_W'(r_awp)) ? r_app - REQ_W'(r_awp) : '0;
                    r_addr     <= '0;
                    r_iss_done <= 1'b0;
                    r_state    <= S_CSCAN;
                end
                // Hand the word to the output register once it is free.
                S_DONE: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        if (r_ok && r_drv_ok) begin
                            r_m_tuser <= 1'b1;
                            r_m_tdata <= {7'd0, r_cap, r_awp, r_acp, r_app, r_req,
                                          r_woc, r_coc, r_wd, r_cd, r_ws, r_cs};
                        end else begin
                            r_m_tuser <= 1'b0;
                            r_m_tdata <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> hw/rtl/frp_tables.sv
// Calibration table memories: level group (code, cold, warm) and drive group (code, power).
// Depends on frp_pkg. Entries never written read as zero through per-entry valid bits.
module frp_tables
    import frp_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_tbl_wr        i_wr,
    input  logic [LW-1:0]  i_lvl_addr,
    input  logic [DW-1:0]  i_drv_addr,
    output t_lvl_rd        o_lvl,
    output t_drv_rd        o_drv
);

    logic [CODE_W-1:0] r_lc_mem [LEVEL_STEPS];
    logic [PWR_W-1:0]  r_cp_mem [LEVEL_STEPS];
    logic [PWR_W-1:0]  r_wp_mem [LEVEL_STEPS];
    logic [CODE_W-1:0] r_dc_mem [DRIVE_STEPS];
    logic [PWR_W-1:0]  r_dp_mem [DRIVE_STEPS];

    logic [LEVEL_STEPS-1:0] r_lc_vld, r_cp_vld, r_wp_vld;
    logic [DRIVE_STEPS-1:0] r_dc_vld, r_dp_vld;

    logic [CODE_W-1:0] r_lc_q, r_dc_q;
    logic [PWR_W-1:0]  r_cp_q, r_wp_q, r_dp_q;
    logic              r_lc_v, r_cp_v, r_wp_v, r_dc_v, r_dp_v;

    logic [LW-1:0] wr_la;
    logic [DW-1:0] wr_da;

    assign wr_la = i_wr.idx[LW-1:0];
    assign wr_da = i_wr.idx[DW-1:0];

    // Valid bits: cleared by reset, set on the first write of an entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc_vld <= '0;
            r_cp_vld <= '0;
            r_wp_vld <= '0;
            r_dc_vld <= '0;
            r_dp_vld <= '0;
        end else if (i_wr.en) begin
            case (i_wr.sel)
                FN_WR_LVL:   r_lc_vld[wr_la] <= 1'b1;
                FN_WR_COLD:  r_cp_vld[wr_la] <= 1'b1;
                FN_WR_WARM:  r_wp_vld[wr_la] <= 1'b1;
                FN_WR_DCODE: r_dc_vld[wr_da] <= 1'b1;
                FN_WR_DPWR:  r_dp_vld[wr_da] <= 1'b1;
                default: ;
            endcase
        end
    end

    // Memory write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            case (i_wr.sel)
                FN_WR_LVL:   r_lc_mem[wr_la] <= i_wr.val[CODE_W-1:0];
                FN_WR_COLD:  r_cp_mem[wr_la] <= i_wr.val;
                FN_WR_WARM:  r_wp_mem[wr_la] <= i_wr.val;
                FN_WR_DCODE: r_dc_mem[wr_da] <= i_wr.val[CODE_W-1:0];
                FN_WR_DPWR:  r_dp_mem[wr_da] <= i_wr.val;
                default: ;
            endcase
        end
    end

    // Registered read of both groups.
    always_ff @(posedge i_clk) begin
        r_lc_q <= r_lc_mem[i_lvl_addr];
        r_cp_q <= r_cp_mem[i_lvl_addr];
        r_wp_q <= r_wp_mem[i_lvl_addr];
        r_dc_q <= r_dc_mem[i_drv_addr];
        r_dp_q <= r_dp_mem[i_drv_addr];
        r_lc_v <= r_lc_vld[i_lvl_addr];
        r_cp_v <= r_cp_vld[i_lvl_addr];
        r_wp_v <= r_wp_vld[i_lvl_addr];
        r_dc_v <= r_dc_vld[i_drv_addr];
        r_dp_v <= r_dp_vld[i_drv_addr];
    end

    assign o_lvl.lc = r_lc_v ? r_lc_q : '0;
    assign o_lvl.cp = r_cp_v ? r_cp_q : '0;
    assign o_lvl.wp = r_wp_v ? r_wp_q : '0;
    assign o_drv.dc = r_dc_v ? r_dc_q : '0;
    assign o_drv.dp = r_dp_v ? r_dp_q : '0;

endmodule
